/* sv/ptw_pkg.sv */
// ============================================================================
// ptw_pkg
// Shared types, codes and helpers for the four-level page table walker.
// ============================================================================
package ptw_pkg;

   localparam int PA_W       = 52;
   localparam int VA_W       = 64;
   localparam int SAVED_VA_W = 48;
   localparam int LIMIT_W    = 53;
   localparam int OWNED_W    = 4;
   localparam int INDEX_BITS = 9;
   localparam int PAGE_BITS  = 12;

   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 120;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // input item kind (tuser)
   localparam logic OP_START    = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   // result kind (tuser)
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_DONE    = 1'b1;

   localparam logic [1:0] STATUS_MAPPED      = 2'd0;
   localparam logic [1:0] STATUS_NOT_PRESENT = 2'd1;
   localparam logic [1:0] STATUS_INVALID     = 2'd2;

   localparam logic [1:0] LEAF_4K   = 2'd0;
   localparam logic [1:0] LEAF_2M   = 2'd1;
   localparam logic [1:0] LEAF_1G   = 2'd2;
   localparam logic [1:0] LEAF_NONE = 2'd3;

   // walk level: 0..3 waiting for that level's entry, else idle
   localparam logic [2:0] LVL_TOP  = 3'd0;
   localparam logic [2:0] LVL_1G   = 3'd1;
   localparam logic [2:0] LVL_2M   = 3'd2;
   localparam logic [2:0] LVL_4K   = 3'd3;
   localparam logic [2:0] LVL_IDLE = 3'd4;

   // register select is paddr bit 3
   localparam logic CSR_SEL_LIMIT = 1'b0;
   localparam logic CSR_SEL_OWNED = 1'b1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 53'h0_0010_0000_0000;
   localparam logic [OWNED_W-1:0] OWNED_RESET = 4'd9;

   localparam int PS_BIT = 7;
   localparam int NX_BIT = 63;

   typedef struct packed {
      logic            kind;
      logic [PA_W-1:0] read_address;
      logic [1:0]      status;
      logic [PA_W-1:0] phys_addr;
      logic [4:0]      leaf_attr;
      logic [1:0]      leaf_level;
   } result_type;

   function automatic logic [INDEX_BITS-1:0] entry_index(
      input logic [SAVED_VA_W-1:0] va,
      input logic [1:0]            level
   );
      logic [INDEX_BITS-1:0] idx;
      case (level)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

   function automatic logic [PA_W-1:0] entry_address(
      input logic [PA_W-1:0]       base,
      input logic [SAVED_VA_W-1:0] va,
      input logic [1:0]            level
   );
      return base + {{(PA_W-INDEX_BITS-3){1'b0}}, entry_index(va, level), 3'b000};
   endfunction

   function automatic logic [4:0] basic_flags(input logic [63:0] e);
      return {1'b0, e[NX_BIT], e[2:0]};
   endfunction

endpackage

/* sv/page_table_walker.sv */
// ============================================================================
// page_table_walker
// Four-level x86-64 page table walk engine with stream in/out and APB regs.
// ============================================================================
// Each transaction on req (a start or a memory response) yields exactly one
// transaction on rsp: a read request for the next table entry or a finished
// walk. One transaction is taken per cycle while rsp is not stalled; each
// passes through the input register and the result register around a single
// pass of address masking, limit compares and one 52-bit add. The walk level
// and saved virtual address update as a transaction passes from the input
// register to the result register, so the next transaction sees them.
module page_table_walker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // root_table[51:0], virt_addr[115:52], read_data[179:116], zero pad
   input  logic [ptw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_address[51:0], status[53:52], phys_addr[105:54],
   // leaf_attr[110:106], leaf_level[112:111], zero pad
   output logic [ptw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // kind
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [ptw_pkg::LIMIT_W-1:0]    limit_ff;
   logic [ptw_pkg::OWNED_W-1:0]    owned_ff;
   logic                           csr_wr;

   logic                           in_valid_ff, in_valid_in;
   logic                           in_op_ff;
   logic [ptw_pkg::PA_W-1:0]       in_root_ff;
   logic [ptw_pkg::VA_W-1:0]       in_va_ff;
   logic [63:0]                    in_data_ff;

   logic [2:0]                     level_ff, level_in;
   logic [ptw_pkg::SAVED_VA_W-1:0] saved_va_ff, saved_va_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   ptw_pkg::result_type            rsp_ff, rsp_in;

   logic                           advance;
   logic                           take;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ptw_pkg::LIMIT_RESET;
         owned_ff <= ptw_pkg::OWNED_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[3] == ptw_pkg::CSR_SEL_LIMIT) begin
            limit_ff <= csr_pwdata[ptw_pkg::LIMIT_W-1:0];
         end else begin
            owned_ff <= csr_pwdata[ptw_pkg::OWNED_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         ptw_pkg::CSR_SEL_LIMIT:
            csr_prdata = {{(ptw_pkg::CSR_DATA_W-ptw_pkg::LIMIT_W){1'b0}}, limit_ff};
         default:
            csr_prdata = {{(ptw_pkg::CSR_DATA_W-ptw_pkg::OWNED_W){1'b0}}, owned_ff};
      endcase
   end

   // handshake
   assign advance     = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready  = ~in_valid_ff | advance;
   assign take        = req_tvalid & req_tready;
   assign in_valid_in = take | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff   <= req_tuser;
         in_root_ff <= req_tdata[51:0];
         in_va_ff   <= req_tdata[115:52];
         in_data_ff <= req_tdata[179:116];
      end
   end

   // walk step
   always_comb begin
      logic [ptw_pkg::PA_W-1:0] next_tbl;
      logic                     root_bad;
      logic                     va_bad;
      logic [1:0]               lvl2;
      logic                     own;

      next_tbl = {in_data_ff[51:12], 12'h000};
      root_bad = (in_root_ff == '0) || (in_root_ff[11:0] != 12'h000) ||
                 ({1'b0, in_root_ff} >= limit_ff);
      va_bad   = (in_va_ff[63:47] != '0) && (in_va_ff[63:47] != '1);
      lvl2     = level_ff[1:0];
      own      = in_data_ff[{2'b00, owned_ff}];

      level_in    = level_ff;
      saved_va_in = saved_va_ff;

      rsp_in.kind         = ptw_pkg::KIND_DONE;
      rsp_in.read_address = '0;
      rsp_in.status       = ptw_pkg::STATUS_INVALID;
      rsp_in.phys_addr    = '0;
      rsp_in.leaf_attr    = '0;
      rsp_in.leaf_level   = ptw_pkg::LEAF_NONE;

      if (in_op_ff == ptw_pkg::OP_START) begin
         level_in = ptw_pkg::LVL_IDLE;
         if (!root_bad && !va_bad) begin
            saved_va_in         = in_va_ff[47:0];
            level_in            = ptw_pkg::LVL_TOP;
            rsp_in.kind         = ptw_pkg::KIND_REQUEST;
            rsp_in.status       = ptw_pkg::STATUS_MAPPED;
            rsp_in.read_address = ptw_pkg::entry_address(in_root_ff, in_va_ff[47:0], 2'd0);
         end
      end else if (level_ff[2]) begin
         level_in = ptw_pkg::LVL_IDLE;
      end else if (!in_data_ff[0]) begin
         level_in      = ptw_pkg::LVL_IDLE;
         rsp_in.status = ptw_pkg::STATUS_NOT_PRESENT;
      end else if (level_ff == ptw_pkg::LVL_1G && in_data_ff[ptw_pkg::PS_BIT]) begin
         level_in          = ptw_pkg::LVL_IDLE;
         rsp_in.status     = ptw_pkg::STATUS_MAPPED;
         rsp_in.phys_addr  = next_tbl + {22'h0, saved_va_ff[29:0]};
         rsp_in.leaf_attr  = ptw_pkg::basic_flags(in_data_ff);
         rsp_in.leaf_level = ptw_pkg::LEAF_1G;
      end else if (level_ff == ptw_pkg::LVL_2M && in_data_ff[ptw_pkg::PS_BIT]) begin
         level_in          = ptw_pkg::LVL_IDLE;
         rsp_in.status     = ptw_pkg::STATUS_MAPPED;
         rsp_in.phys_addr  = next_tbl + {31'h0, saved_va_ff[20:0]};
         rsp_in.leaf_attr  = ptw_pkg::basic_flags(in_data_ff);
         rsp_in.leaf_level = ptw_pkg::LEAF_2M;
      end else if (level_ff == ptw_pkg::LVL_4K) begin
         level_in          = ptw_pkg::LVL_IDLE;
         rsp_in.status     = ptw_pkg::STATUS_MAPPED;
         rsp_in.phys_addr  = {in_data_ff[51:12], saved_va_ff[11:0]};
         rsp_in.leaf_attr  = ptw_pkg::basic_flags(in_data_ff) | {own, 4'b0000};
         rsp_in.leaf_level = ptw_pkg::LEAF_4K;
      end else if ((next_tbl == '0) || ({1'b0, next_tbl} >= limit_ff)) begin
         level_in = ptw_pkg::LVL_IDLE;
      end else begin
         level_in            = level_ff + 3'd1;
         rsp_in.kind         = ptw_pkg::KIND_REQUEST;
         rsp_in.status       = ptw_pkg::STATUS_MAPPED;
         rsp_in.read_address = ptw_pkg::entry_address(next_tbl, saved_va_ff, lvl2 + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= ptw_pkg::LVL_IDLE;
         saved_va_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            level_ff    <= level_in;
            saved_va_ff <= saved_va_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {7'b0, rsp_ff.leaf_level, rsp_ff.leaf_attr, rsp_ff.phys_addr,
                        rsp_ff.status, rsp_ff.read_address};

`ifndef SYNTHESIS
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= ptw_pkg::LVL_IDLE)
      else $error("walk level out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == ptw_pkg::KIND_DONE |-> level_ff == ptw_pkg::LVL_IDLE)
      else $error("finished transaction while walk still active");

   a_request_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == ptw_pkg::KIND_REQUEST |->
         level_ff != ptw_pkg::LVL_IDLE)
      else $error("read request issued with walk idle");

   a_unmapped_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !(rsp_ff.kind == ptw_pkg::KIND_DONE &&
                        rsp_ff.status == ptw_pkg::STATUS_MAPPED) |->
         rsp_ff.phys_addr == '0 && rsp_ff.leaf_level == ptw_pkg::LEAF_NONE)
      else $error("leaf fields set on non-mapped result");
`endif

endmodule
